FILE: rtl/dpdb_pkg.sv
package dpdb_pkg;

  localparam int KIND_W  = 2;
  localparam int COUNT_W = 22;
  localparam int OFFS_W  = 12;
  localparam int FRAME_W = 20;
  localparam int OP_W    = 2;
  localparam int ENTRY_W = 9;
  localparam int ADDR_W  = 32;
  localparam int BYTES_W = 13;

  // Input item kinds.
  localparam logic [KIND_W-1:0] KIND_REQUEST  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAGE     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd2;

  // Result operations.
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_ACCEPT = 2'd2;
  localparam logic [OP_W-1:0] OP_REJECT = 2'd3;

  // Commands passed from the front to the back.
  localparam logic [1:0] CMD_REJECT = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  typedef struct packed {
    logic [1:0]         code;
    logic [ENTRY_W-1:0] entry;
    logic [ADDR_W-1:0]  addr;
    logic [BYTES_W-1:0] bytes;
    logic               eot;
    logic               clear_valid;
    logic [ENTRY_W-1:0] clear_index;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [ENTRY_W-1:0] entry_index;
    logic [ADDR_W-1:0]  phys_addr;
    logic [BYTES_W-1:0] entry_bytes;
    logic               end_of_table;
    logic               last;
  } beat_t;

endpackage

FILE: rtl/dpdb_if.sv
interface dpdb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [21:0] byte_count;
  logic [11:0] start_offset;
  logic [19:0] phys_frame;

  modport source(output valid, kind, byte_count, start_offset, phys_frame, input ready);
  modport sink(input valid, kind, byte_count, start_offset, phys_frame, output ready);
endinterface

interface dpdb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [8:0]  entry_index;
  logic [31:0] phys_addr;
  logic [12:0] entry_bytes;
  logic        end_of_table;
  logic        last;

  modport source(output valid, op, entry_index, phys_addr, entry_bytes, end_of_table, last,
                 input ready);
  modport sink(input valid, op, entry_index, phys_addr, entry_bytes, end_of_table, last,
               output ready);
endinterface

FILE: rtl/dma_prd_descriptor_builder.sv
// Channel  Dir  Contents
// item     in   kind, byte_count, start_offset, phys_frame
// result   out  op, entry_index, phys_addr, entry_bytes, end_of_table, last
//
// The front takes one item per cycle unless the command queue is full, and
// posts a command to it (QUEUE_DEPTH entries). The back drains it through a
// registered output at one beat per cycle while result.ready is high: page
// items give one beat, a request's final page two or three, so the sustained
// rate is set by the back's beat count. Synchronous rst clears the table
// state and empties the queue. item.ready drops only while the queue is full.
module dma_prd_descriptor_builder
  import dpdb_pkg::*;
#(
  parameter int TABLE_ENTRIES = 512,
  parameter int PAGE_BYTES    = 4096,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic       clk,
  input  logic       rst,
  dpdb_in_if.sink    item,
  dpdb_out_if.source result
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_data;
  cmd_t q_head;

  dpdb_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .PAGE_BYTES   (PAGE_BYTES)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .q_full(q_full),
    .q_push(q_push),
    .q_data(q_data)
  );

  dpdb_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_data),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  dpdb_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (q_head),
    .empty (q_empty),
    .pop   (q_pop),
    .result(result)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command queue overflow");

  a_clear_then_accept: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ready && result.op == OP_CLEAR)
      |=> (result.valid && result.op == OP_ACCEPT && result.last))
    else $error("clear beat not followed by accept beat");

  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.op == OP_REJECT || result.op == OP_ACCEPT)) |-> result.last)
    else $error("closing beat without last");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty command queue");
`endif

endmodule

FILE: rtl/dpdb_front.sv
module dpdb_front
  import dpdb_pkg::*;
#(
  parameter int TABLE_ENTRIES = 512,
  parameter int PAGE_BYTES    = 4096
) (
  input  logic        clk,
  input  logic        rst,
  dpdb_in_if.sink     item,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_data
);

  localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
  localparam int OFF_W  = $clog2(PAGE_BYTES);
  localparam int SIZE_W = OFF_W + 1;

  logic [FILL_W-1:0]  fill_index, fill_index_next;
  logic [FILL_W-1:0]  request_first, request_first_next;
  logic [COUNT_W-1:0] bytes_left, bytes_left_next;
  logic [OFF_W-1:0]   page_offset, page_offset_next;
  logic               request_active, request_active_next;

  logic               accept;
  logic               table_full;
  logic               full_after;
  logic [OFF_W-1:0]   off;
  logic [SIZE_W-1:0]  size_room;
  logic [SIZE_W-1:0]  size;
  logic [COUNT_W-1:0] left_after;
  logic               done;
  logic [ADDR_W-1:0]  addr;

  assign item.ready = !q_full;
  assign accept     = item.valid && item.ready;
  assign table_full = fill_index >= FILL_W'(TABLE_ENTRIES);
  assign full_after = fill_index == FILL_W'(TABLE_ENTRIES - 1);

  // The first page of a request carries the buffer offset.
  assign off        = (fill_index == request_first) ? page_offset : '0;
  assign size_room  = SIZE_W'(PAGE_BYTES) - {1'b0, off};
  assign size       = (bytes_left < COUNT_W'(size_room)) ? SIZE_W'(bytes_left) : size_room;
  assign left_after = bytes_left - COUNT_W'(size);
  assign done       = left_after == '0;
  assign addr       = (ADDR_W'(item.phys_frame) << OFF_W) + ADDR_W'(off);

  always_comb begin
    fill_index_next     = fill_index;
    request_first_next  = request_first;
    bytes_left_next     = bytes_left;
    page_offset_next    = page_offset;
    request_active_next = request_active;
    q_push              = 1'b0;
    q_data              = '0;
    if (accept) begin
      unique case (item.kind)
        KIND_REQUEST: begin
          if (item.byte_count == '0 || table_full || request_active) begin
            q_push      = 1'b1;
            q_data.code = CMD_REJECT;
          end else begin
            bytes_left_next     = item.byte_count;
            page_offset_next    = OFF_W'(item.start_offset);
            request_first_next  = fill_index;
            request_active_next = 1'b1;
          end
        end
        KIND_PAGE: begin
          if (request_active && !table_full) begin
            q_push            = 1'b1;
            q_data.entry      = ENTRY_W'(fill_index);
            q_data.addr       = addr;
            q_data.bytes      = BYTES_W'(size);
            q_data.eot        = done;
            q_data.clear_index = ENTRY_W'(request_first - FILL_W'(1));
            q_data.clear_valid = request_first != '0;
            fill_index_next   = fill_index + FILL_W'(1);
            bytes_left_next   = left_after;
            if (!done && !full_after) begin
              q_data.code = CMD_WRITE;
            end else begin
              q_data.code         = CMD_FINISH;
              request_active_next = 1'b0;
              bytes_left_next     = '0;
            end
          end
        end
        KIND_COMPLETE: begin
          fill_index_next     = '0;
          request_first_next  = '0;
          bytes_left_next     = '0;
          page_offset_next    = '0;
          request_active_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_index     <= '0;
      request_first  <= '0;
      bytes_left     <= '0;
      page_offset    <= '0;
      request_active <= 1'b0;
    end else begin
      fill_index     <= fill_index_next;
      request_first  <= request_first_next;
      bytes_left     <= bytes_left_next;
      page_offset    <= page_offset_next;
      request_active <= request_active_next;
    end
  end

endmodule

FILE: rtl/dpdb_queue.sv
module dpdb_queue
  import dpdb_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/dpdb_back.sv
module dpdb_back
  import dpdb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  logic       empty,
  output logic       pop,
  dpdb_out_if.source result
);

  logic [1:0] step;
  logic       out_valid;
  beat_t      out_beat;
  beat_t      beat;
  logic       final_beat;
  logic       load;

  assign load = !out_valid || result.ready;
  assign pop  = load && !empty && final_beat;

  // A finishing command expands to write, optional clear, then accept.
  always_comb begin
    beat       = '0;
    final_beat = 1'b1;
    unique case (head.code)
      CMD_WRITE: begin
        beat.op          = OP_WRITE;
        beat.entry_index = head.entry;
        beat.phys_addr   = head.addr;
        beat.entry_bytes = head.bytes;
        beat.last        = 1'b1;
      end
      CMD_FINISH: begin
        if (step == 2'd0) begin
          beat.op           = OP_WRITE;
          beat.entry_index  = head.entry;
          beat.phys_addr    = head.addr;
          beat.entry_bytes  = head.bytes;
          beat.end_of_table = head.eot;
          final_beat        = 1'b0;
        end else if (step == 2'd1 && head.clear_valid) begin
          beat.op          = OP_CLEAR;
          beat.entry_index = head.clear_index;
          final_beat       = 1'b0;
        end else begin
          beat.op   = OP_ACCEPT;
          beat.last = 1'b1;
        end
      end
      default: begin
        beat.op   = OP_REJECT;
        beat.last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) begin
        step <= final_beat ? 2'd0 : step + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      out_beat <= beat;
    end
  end

  assign result.valid        = out_valid;
  assign result.op           = out_beat.op;
  assign result.entry_index  = out_beat.entry_index;
  assign result.phys_addr    = out_beat.phys_addr;
  assign result.entry_bytes  = out_beat.entry_bytes;
  assign result.end_of_table = out_beat.end_of_table;
  assign result.last         = out_beat.last;

endmodule
